// ----- design/rleid_pkg.sv -----
// Package for the run-length image stream decoder.
// Holds the channel word types, result kind and error codes, and the signature table.
// No dependencies.
package rleid_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_VERSION   = 3'd2;
  localparam logic [2:0] ERR_COMPRESS  = 3'd3;
  localparam logic [2:0] ERR_SHORT_ROW = 3'd4;

  localparam logic [7:0] OPAQUE = 8'd255;

  localparam logic [7:0] SIG_CHARS [3] = '{8'h4E, 8'h56, 8'h47};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } rleid_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  opacity;
    logic [7:0]  run_length;
    logic        row_end;
    logic        image_end;
    logic [2:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
  } rleid_out_t;

endpackage

// ----- design/rle_image_stream_decoder_core.sv -----
// Run-length image stream decoder, top level.
// Depends on rleid_pkg for the word types and codes.
//
// Usage:
// The input channel carries one file byte per word, with file_start set on
// the first byte of each file; that byte restarts the parser from any phase.
// Bytes outside a file (after an error or a finished image) are dropped.
// The output channel carries at most one result word per input word: a
// header, a pixel run, an error or an empty-image end marker.
// Throughput: one input word per cycle while in_stall_o is low. Each byte is decoded
// by the logic between the parser state registers and the output register, which
// offers its result on out_valid_o.
// When the receiver stalls, one further result is caught in a skid register,
// and in_stall_o rises only once that skid register holds a word; it falls
// again the cycle after the output word is taken and the skid word moves up.
// Reset returns the parser to idle, ignoring bytes, and empties both output
// registers. No clearing pass is needed.
module rle_image_stream_decoder_core
  import rleid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  rleid_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rleid_out_t out_data_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SIG,
    PH_VER,
    PH_COMP,
    PH_ALPHA,
    PH_WIDTH,
    PH_HEIGHT,
    PH_ROWLEN,
    PH_ROWDATA
  } phase_e;

  phase_e      phase_q, phase_d, cur_phase;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d, cur_hdr_cnt;
  logic        sig_mis_q, sig_mis_d, cur_sig_mis;
  logic        ver3_q, ver3_d;
  logic        comp_rle_q, comp_rle_d, cur_comp_rle;
  logic        comp_bad_q, comp_bad_d, cur_comp_bad;
  logic        four_q, four_d, cur_four;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] rows_done_q, rows_done_d;
  logic [15:0] row_left_q, row_left_d;
  logic [15:0] pix_left_q, pix_left_d;
  logic [2:0]  comp_idx_q, comp_idx_d;
  logic [7:0]  px_q [4];
  logic [7:0]  px_d [4];
  logic [7:0]  run_cnt_q, run_cnt_d;
  logic [7:0]  word_hi_q, word_hi_d;

  logic        out_vld_q, skid_vld_q;
  rleid_out_t  out_q, skid_q;

  logic        in_fire, out_take;
  logic        res_vld;
  rleid_out_t  res;

  logic [15:0] word_val;
  logic [15:0] rows_inc;
  logic [15:0] row_left_dec;
  logic [2:0]  idx_inc;
  logic [2:0]  pix_total;
  logic [1:0]  slot;
  logic [7:0]  run_n;
  logic [15:0] run_clip;
  logic        run_emit;

  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_take    = out_vld_q & ~out_stall_i;
  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    sig_mis_d   = sig_mis_q;
    ver3_d      = ver3_q;
    comp_rle_d  = comp_rle_q;
    comp_bad_d  = comp_bad_q;
    four_d      = four_q;
    width_d     = width_q;
    height_d    = height_q;
    rows_done_d = rows_done_q;
    row_left_d  = row_left_q;
    pix_left_d  = pix_left_q;
    comp_idx_d  = comp_idx_q;
    px_d        = px_q;
    run_cnt_d   = run_cnt_q;
    word_hi_d   = word_hi_q;
    res         = '0;
    res_vld     = 1'b0;

    // A start-flagged byte sees the parser as freshly reset and at the signature.
    cur_phase    = phase_q;
    cur_hdr_cnt  = hdr_cnt_q;
    cur_sig_mis  = sig_mis_q;
    cur_comp_rle = comp_rle_q;
    cur_comp_bad = comp_bad_q;
    cur_four     = four_q;
    if (in_data_i.file_start) begin
      cur_phase    = PH_SIG;
      cur_hdr_cnt  = 2'd0;
      cur_sig_mis  = 1'b0;
      cur_comp_rle = 1'b0;
      cur_comp_bad = 1'b0;
      cur_four     = 1'b0;
    end

    word_val     = {word_hi_q, in_data_i.data_byte};
    rows_inc     = rows_done_q + 16'd1;
    row_left_dec = row_left_q - 16'd1;
    idx_inc      = comp_idx_q + 3'd1;
    pix_total    = 3'd3 + {2'd0, cur_four} + {2'd0, cur_comp_rle};
    slot         = comp_idx_q[1:0] - {1'b0, cur_comp_rle};
    run_n        = cur_comp_rle ? run_cnt_q : 8'd1;
    run_clip     = ({8'd0, run_n} > pix_left_q) ? pix_left_q : {8'd0, run_n};
    run_emit     = 1'b0;

    if (in_fire) begin
      phase_d    = cur_phase;
      hdr_cnt_d  = cur_hdr_cnt;
      sig_mis_d  = cur_sig_mis;
      comp_rle_d = cur_comp_rle;
      comp_bad_d = cur_comp_bad;
      four_d     = cur_four;

      case (cur_phase)
        PH_SIG: begin
          if (in_data_i.data_byte != SIG_CHARS[cur_hdr_cnt]) sig_mis_d = 1'b1;
          if (cur_hdr_cnt == 2'd2) begin
            hdr_cnt_d = 2'd0;
            phase_d   = PH_VER;
          end else begin
            hdr_cnt_d = cur_hdr_cnt + 2'd1;
          end
        end
        PH_VER: begin
          ver3_d = (in_data_i.data_byte == 8'd3);
          if (cur_sig_mis) begin
            res_vld        = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_SIGNATURE;
            phase_d        = PH_IDLE;
          end else if (in_data_i.data_byte < 8'd1 || in_data_i.data_byte > 8'd3) begin
            res_vld        = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_VERSION;
            phase_d        = PH_IDLE;
          end else begin
            phase_d = (in_data_i.data_byte >= 8'd2) ? PH_COMP : PH_WIDTH;
          end
        end
        PH_COMP: begin
          comp_rle_d = (in_data_i.data_byte == 8'd1);
          comp_bad_d = (in_data_i.data_byte > 8'd1);
          phase_d    = ver3_q ? PH_ALPHA : PH_WIDTH;
        end
        PH_ALPHA: begin
          four_d  = (in_data_i.data_byte != 8'd0);
          phase_d = PH_WIDTH;
        end
        PH_WIDTH, PH_HEIGHT, PH_ROWLEN: begin
          if (cur_hdr_cnt == 2'd0) begin
            word_hi_d = in_data_i.data_byte;
            hdr_cnt_d = 2'd1;
          end else begin
            hdr_cnt_d = 2'd0;
            if (cur_phase == PH_WIDTH) begin
              width_d = word_val;
              phase_d = PH_HEIGHT;
            end else if (cur_phase == PH_HEIGHT) begin
              height_d           = word_val;
              res_vld            = 1'b1;
              res.image_width    = width_q;
              res.image_height   = word_val;
              res.has_alpha      = cur_four;
              if (word_val == 16'd0) begin
                res.kind      = KIND_EMPTY;
                res.image_end = 1'b1;
                phase_d       = PH_IDLE;
              end else begin
                res.kind    = KIND_HEADER;
                rows_done_d = 16'd0;
                pix_left_d  = width_q;
                comp_idx_d  = 3'd0;
                phase_d     = PH_ROWLEN;
              end
            end else if (cur_comp_bad) begin
              res_vld        = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_COMPRESS;
              phase_d        = PH_IDLE;
            end else begin
              row_left_d = word_val;
              if (word_val == 16'd0) begin
                // Empty row: finish it at once.
                if (pix_left_q != 16'd0) begin
                  res_vld        = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_SHORT_ROW;
                  phase_d        = PH_IDLE;
                end else begin
                  rows_done_d = rows_inc;
                  if (rows_inc == height_q) begin
                    phase_d = PH_IDLE;
                    if (width_q == 16'd0) begin
                      res_vld          = 1'b1;
                      res.kind         = KIND_EMPTY;
                      res.image_end    = 1'b1;
                      res.image_width  = width_q;
                      res.image_height = height_q;
                      res.has_alpha    = cur_four;
                    end
                  end else begin
                    pix_left_d = width_q;
                    comp_idx_d = 3'd0;
                    phase_d    = PH_ROWLEN;
                  end
                end
              end else begin
                phase_d = PH_ROWDATA;
              end
            end
          end
        end
        PH_ROWDATA: begin
          row_left_d = row_left_dec;
          if (pix_left_q != 16'd0) begin
            if (cur_comp_rle && comp_idx_q == 3'd0) begin
              run_cnt_d = in_data_i.data_byte;
            end else begin
              px_d[slot] = in_data_i.data_byte;
            end
            if (idx_inc >= pix_total) begin
              comp_idx_d = 3'd0;
              if (run_n != 8'd0) begin
                run_emit       = 1'b1;
                pix_left_d     = pix_left_q - run_clip;
                res_vld        = 1'b1;
                res.kind       = KIND_RUN;
                res.red        = px_d[0];
                res.green      = px_d[1];
                res.blue       = px_d[2];
                res.opacity    = cur_four ? px_d[3] : OPAQUE;
                res.run_length = run_clip[7:0];
                if (pix_left_d == 16'd0) begin
                  res.row_end   = 1'b1;
                  res.image_end = (rows_inc == height_q) && (rows_done_q != 16'hFFFF);
                end
              end
            end else begin
              comp_idx_d = idx_inc;
            end
          end
          if (row_left_dec == 16'd0) begin
            if (pix_left_d != 16'd0) begin
              // Row ran out early: the error replaces any run from this byte.
              res            = '0;
              res_vld        = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SHORT_ROW;
              phase_d        = PH_IDLE;
            end else begin
              rows_done_d = rows_inc;
              if (rows_inc == height_q) begin
                phase_d = PH_IDLE;
                if (width_q == 16'd0 && !run_emit) begin
                  res_vld          = 1'b1;
                  res.kind         = KIND_EMPTY;
                  res.image_end    = 1'b1;
                  res.image_width  = width_q;
                  res.image_height = height_q;
                  res.has_alpha    = cur_four;
                end
              end else begin
                pix_left_d = width_q;
                comp_idx_d = 3'd0;
                hdr_cnt_d  = 2'd0;
                phase_d    = PH_ROWLEN;
              end
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hdr_cnt_q   <= 2'd0;
      sig_mis_q   <= 1'b0;
      ver3_q      <= 1'b0;
      comp_rle_q  <= 1'b0;
      comp_bad_q  <= 1'b0;
      four_q      <= 1'b0;
      width_q     <= 16'd0;
      height_q    <= 16'd0;
      rows_done_q <= 16'd0;
      row_left_q  <= 16'd0;
      pix_left_q  <= 16'd0;
      comp_idx_q  <= 3'd0;
      run_cnt_q   <= 8'd0;
      word_hi_q   <= 8'd0;
      out_vld_q   <= 1'b0;
      skid_vld_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      sig_mis_q   <= sig_mis_d;
      ver3_q      <= ver3_d;
      comp_rle_q  <= comp_rle_d;
      comp_bad_q  <= comp_bad_d;
      four_q      <= four_d;
      width_q     <= width_d;
      height_q    <= height_d;
      rows_done_q <= rows_done_d;
      row_left_q  <= row_left_d;
      pix_left_q  <= pix_left_d;
      comp_idx_q  <= comp_idx_d;
      run_cnt_q   <= run_cnt_d;
      word_hi_q   <= word_hi_d;
      if (skid_vld_q) begin
        if (out_take) skid_vld_q <= 1'b0;
      end else if (res_vld) begin
        if (!out_vld_q || out_take) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Pixel bytes and result words carry no reset.
  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    if (skid_vld_q) begin
      if (out_take) out_q <= skid_q;
    end else if (res_vld) begin
      if (!out_vld_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule

// ----- design/rleid_checker.sv -----
// Port-level checker for the run-length image stream decoder, with its bind.
// Depends on rleid_pkg for the result kind codes.
module rleid_checker
  import rleid_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input rleid_in_t  in_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input rleid_out_t out_data_o
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // The input side stalls only while a result word is waiting.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Input stall only follows a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output backpressure");

  // Runs always hold at least one pixel; errors always carry a code.
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_RUN |-> out_data_o.run_length != 8'd0)
    else $error("empty pixel run");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_ERROR |-> out_data_o.error_code != ERR_NONE)
    else $error("error word without code");

endmodule

bind rle_image_stream_decoder_core rleid_checker u_rleid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- test/tb_rle_image_stream_decoder_core.sv -----
// Testbench for rle_image_stream_decoder_core: streams image files byte by byte and
// checks every result word against a byte-level decoder kept in a scoreboard class.
// Depends on rleid_pkg and the decoder RTL.
module tb_rle_image_stream_decoder_core;
  import rleid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET    = 1350;
  localparam int unsigned CALM_TAIL      = 180;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SIG, PH_VER, PH_COMP, PH_ALPHA, PH_WIDTH, PH_HEIGHT, PH_ROWLEN, PH_ROWDATA
  } parse_phase_e;

  class rleid_decode_scoreboard;
    parse_phase_e ph;
    logic [2:0]   hdr_cnt;
    logic [7:0]   version;
    logic [7:0]   comp;
    logic         alpha4;
    logic [15:0]  wid;
    logic [15:0]  hgt;
    logic [15:0]  rows_done;
    logic [15:0]  bytes_left;
    logic [15:0]  px_left;
    logic [2:0]   comp_idx;
    logic [7:0]   pix [4];
    logic [7:0]   cnt;
    logic         sig_bad;
    logic [7:0]   word_hi;
    rleid_out_t   results_due [$];
    int unsigned  fails;

    function new();
      fails = 0;
      clear_state();
    endfunction

    function void clear_state();
      ph = PH_IDLE;
      hdr_cnt = '0;
      version = '0;
      comp = '0;
      alpha4 = 1'b0;
      wid = '0;
      hgt = '0;
      rows_done = '0;
      bytes_left = '0;
      px_left = '0;
      comp_idx = '0;
      foreach (pix[i]) pix[i] = '0;
      cnt = '0;
      sig_bad = 1'b0;
      word_hi = '0;
    endfunction

    function bit raise_error(inout rleid_out_t r, input logic [2:0] code);
      r.kind = KIND_ERROR;
      r.error_code = code;
      ph = PH_IDLE;
      return 1'b1;
    endfunction

    function bit put_dims(inout rleid_out_t r, input logic [1:0] kind);
      r.kind = kind;
      r.image_end = (kind == KIND_EMPTY);
      r.image_width = wid;
      r.image_height = hgt;
      r.has_alpha = alpha4;
      return 1'b1;
    endfunction

    function void begin_row();
      px_left = wid;
      comp_idx = '0;
      hdr_cnt = '0;
      ph = PH_ROWLEN;
    endfunction

    // Row bytes used up: a missing pixel turns whatever was decoded into a short-row error.
    function bit close_row(inout rleid_out_t r, input bit emitted);
      if (px_left != 0) begin
        r = '0;
        return raise_error(r, ERR_SHORT_ROW);
      end
      rows_done = rows_done + 16'd1;
      if (rows_done == hgt) begin
        ph = PH_IDLE;
        if (wid == 0 && !emitted) return put_dims(r, KIND_EMPTY);
        return emitted;
      end
      begin_row();
      return emitted;
    endfunction

    function bit row_byte(inout rleid_out_t r, input logic [7:0] b);
      logic [7:0]  bpp;
      logic [7:0]  off;
      logic [7:0]  idx;
      logic [15:0] n;
      bit          emitted;
      emitted = 1'b0;
      bytes_left = bytes_left - 16'd1;
      if (px_left != 0) begin
        bpp = alpha4 ? 8'd4 : 8'd3;
        off = (comp == 8'd1) ? 8'd1 : 8'd0;
        idx = 8'(comp_idx);
        if (off != 0 && idx == 0) cnt = b;
        else pix[2'(idx - off)] = b;
        idx = idx + 8'd1;
        if (idx >= bpp + off) begin
          n = (off != 0) ? 16'(cnt) : 16'd1;
          comp_idx = '0;
          if (n != 0) begin
            if (n > px_left) n = px_left;
            px_left = px_left - n;
            r.kind = KIND_RUN;
            r.red = pix[0];
            r.green = pix[1];
            r.blue = pix[2];
            r.opacity = alpha4 ? pix[3] : OPAQUE;
            r.run_length = n[7:0];
            if (px_left == 0) begin
              r.row_end = 1'b1;
              if (32'(rows_done) + 32'd1 == 32'(hgt)) r.image_end = 1'b1;
            end
            emitted = 1'b1;
          end
        end else begin
          comp_idx = idx[2:0];
        end
      end
      if (bytes_left == 0) return close_row(r, emitted);
      return emitted;
    endfunction

    function bit decode_byte(input rleid_in_t w, output rleid_out_t r);
      logic [7:0]  b;
      logic [15:0] v;
      b = w.data_byte;
      r = '0;
      if (w.file_start) begin
        clear_state();
        ph = PH_SIG;
      end
      case (ph)
        PH_SIG: begin
          if (b != SIG_CHARS[hdr_cnt % 3]) sig_bad = 1'b1;
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt >= 3) begin
            hdr_cnt = '0;
            ph = PH_VER;
          end
          return 1'b0;
        end
        PH_VER: begin
          version = b;
          if (sig_bad) return raise_error(r, ERR_SIGNATURE);
          if (b < 1 || b > 3) return raise_error(r, ERR_VERSION);
          ph = (b >= 2) ? PH_COMP : PH_WIDTH;
          return 1'b0;
        end
        PH_COMP: begin
          comp = b;
          ph = (version >= 3) ? PH_ALPHA : PH_WIDTH;
          return 1'b0;
        end
        PH_ALPHA: begin
          alpha4 = (b != 0);
          ph = PH_WIDTH;
          return 1'b0;
        end
        PH_WIDTH, PH_HEIGHT, PH_ROWLEN: begin
          if (hdr_cnt == 0) begin
            word_hi = b;
            hdr_cnt = 3'd1;
            return 1'b0;
          end
          hdr_cnt = '0;
          v = {word_hi, b};
          if (ph == PH_WIDTH) begin
            wid = v;
            ph = PH_HEIGHT;
            return 1'b0;
          end
          if (ph == PH_HEIGHT) begin
            hgt = v;
            if (v == 0) begin
              ph = PH_IDLE;
              return put_dims(r, KIND_EMPTY);
            end
            rows_done = '0;
            begin_row();
            return put_dims(r, KIND_HEADER);
          end
          if (comp > 1) return raise_error(r, ERR_COMPRESS);
          bytes_left = v;
          if (v == 0) return close_row(r, 1'b0);
          ph = PH_ROWDATA;
          return 1'b0;
        end
        PH_ROWDATA: return row_byte(r, b);
        default: begin
          ph = PH_IDLE;
          return 1'b0;
        end
      endcase
    endfunction

    function void note_byte(rleid_in_t w);
      rleid_out_t r;
      if (decode_byte(w, r)) results_due.push_back(r);
    endfunction

    function void match_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(rleid_out_t got);
      rleid_out_t want;
      if (results_due.size() == 0) begin
        $error("result word with none pending: kind %0d", got.kind);
        fails++;
        return;
      end
      want = results_due.pop_front();
      match_field("kind", 16'(want.kind), 16'(got.kind));
      match_field("red", 16'(want.red), 16'(got.red));
      match_field("green", 16'(want.green), 16'(got.green));
      match_field("blue", 16'(want.blue), 16'(got.blue));
      match_field("opacity", 16'(want.opacity), 16'(got.opacity));
      match_field("run_length", 16'(want.run_length), 16'(got.run_length));
      match_field("row_end", 16'(want.row_end), 16'(got.row_end));
      match_field("image_end", 16'(want.image_end), 16'(got.image_end));
      match_field("error_code", 16'(want.error_code), 16'(got.error_code));
      match_field("image_width", want.image_width, got.image_width);
      match_field("image_height", want.image_height, got.image_height);
      match_field("has_alpha", 16'(want.has_alpha), 16'(got.has_alpha));
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  rleid_in_t  in_data = '0;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  rleid_out_t out_data_o;

  rleid_decode_scoreboard sb = new();
  rleid_in_t   file_q [$];
  int unsigned bytes_sent = 0;
  int unsigned idle_pct = 0;
  bit          calm = 1'b0;
  bit          no_gap = 1'b0;
  bit          hold_req = 1'b0;

  rle_image_stream_decoder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic put(input logic [7:0] b, input logic start = 1'b0);
    file_q.push_back('{data_byte: b, file_start: start});
  endtask

  task automatic put_word(input logic [15:0] v);
    put(v[15:8]);
    put(v[7:0]);
  endtask

  task automatic put_sig();
    put(SIG_CHARS[0], 1'b1);
    put(SIG_CHARS[1]);
    put(SIG_CHARS[2]);
  endtask

  task automatic put_head(input logic [7:0] ver, input logic [7:0] cmp, input logic [7:0] alph,
                          input logic [15:0] w, input logic [15:0] h);
    put_sig();
    put(ver);
    if (ver >= 2) put(cmp);
    if (ver == 3) put(alph);
    put_word(w);
    put_word(h);
  endtask

  task automatic send_byte(input rleid_in_t word);
    int unsigned gap;
    gap = (calm || no_gap || $urandom_range(0, 99) >= idle_pct) ? 0 : $urandom_range(1, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= word;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(word);
    bytes_sent++;
  endtask

  task automatic send_all();
    foreach (file_q[i]) send_byte(file_q[i]);
    file_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Mostly well-formed files with random content; a few carry header or row damage, or are cut short or restarted.
  task automatic add_random_file();
    int unsigned ver, cmp, alph, w, h, sel, bpp, rem, c, len, r, base, cut;
    logic [7:0]  row_q [$];
    bit          rle;
    sel = $urandom_range(0, 99);
    ver = $urandom_range(1, 3);
    cmp = $urandom_range(0, 1);
    alph = $urandom_range(0, 1) ? $urandom_range(1, 255) : 0;
    if (sel < 5) ver = $urandom_range(0, 1) ? 0 : $urandom_range(4, 255);
    else if (sel < 8) begin
      ver = $urandom_range(2, 3);
      cmp = $urandom_range(2, 255);
    end
    r = $urandom_range(0, 99);
    if (r < 6) w = 0;
    else if (r < 88) w = $urandom_range(1, 6);
    else if (r < 96) w = $urandom_range(7, 40);
    else w = $urandom_range(200, 300);
    rle = (ver >= 2 && ver <= 3 && cmp == 1);
    if (!rle && w > 40) w = 40;
    h = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, (w > 6) ? 2 : 4);
    bpp = (ver == 3 && alph != 0) ? 4 : 3;
    if ($urandom_range(0, 99) < 5) repeat ($urandom_range(1, 3)) put(8'($urandom));
    base = file_q.size();
    put_head(8'(ver), 8'(cmp), 8'(alph), 16'(w), 16'(h));
    if (sel >= 8 && sel < 11)
      file_q[base + $urandom_range(0, 2)].data_byte ^= 8'($urandom_range(1, 255));
    if (ver == 0 || ver > 3) return;
    for (int row = 0; row < h; row++) begin
      row_q.delete();
      if (rle) begin
        rem = w;
        while (rem > 0) begin
          r = $urandom_range(0, 99);
          if (r < 8) c = 0;
          else if (r < 14) begin
            c = rem + $urandom_range(1, 4);
            if (c > 255) c = 255;
          end else if (r < 30) c = $urandom_range(1, (rem > 255) ? 255 : rem);
          else c = $urandom_range(1, (rem < 4) ? rem : 4);
          row_q.push_back(8'(c));
          repeat (bpp) row_q.push_back(8'($urandom));
          rem = (c >= rem) ? 0 : rem - c;
        end
      end else begin
        repeat (w * bpp) row_q.push_back(8'($urandom));
      end
      len = row_q.size();
      r = $urandom_range(0, 99);
      if (r < 4) len = (len == 0) ? 0 : $urandom_range(0, len - 1);
      else if (r < 12) begin
        repeat ($urandom_range(1, 3)) row_q.push_back(8'($urandom));
        len = row_q.size();
      end
      put_word(16'(len));
      for (int i = 0; i < len; i++) put(row_q[i]);
    end
    // Cut the file short, or restart it from a stray start-flagged byte.
    r = $urandom_range(0, 99);
    if (r < 4 && file_q.size() > base + 5) begin
      cut = $urandom_range(base + 4, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (r < 6) begin
      file_q[$urandom_range(base + 1, file_q.size() - 1)].file_start = 1'b1;
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left, stall_pct, stretch;
    stall_left = 0;
    stall_pct = 0;
    stretch = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall) sb.check_result(out_data_o);
      if (stretch == 0) begin
        stretch = $urandom_range(50, 250);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 8;
      end else begin
        stretch--;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (calm) stall_left = 0;
      else if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 18);
      out_stall <= (stall_left != 0);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    bit pressure_done;
    pressure_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stray bytes while idle.
    put(8'h00);
    put(8'hFF);
    // Version 1, raw pixels at both extremes.
    put_head(8'd1, 8'd0, 8'd0, 16'd2, 16'd1);
    put_word(16'd6);
    repeat (3) put(8'h00);
    repeat (3) put(8'hFF);
    // Version 3 RLE with alpha: full count, zero count, count clipped to the row.
    put_head(8'd3, 8'd1, 8'h80, 16'd300, 16'd1);
    put_word(16'd15);
    put(8'd255); put(8'h01); put(8'h02); put(8'h03); put(8'h04);
    put(8'd0);   put(8'h11); put(8'h22); put(8'h33); put(8'h44);
    put(8'd100); put(8'hFF); put(8'hFE); put(8'hFD); put(8'h00);
    // Leftover bytes in one row, then a short row whose last byte completes a pixel.
    put_head(8'd2, 8'd0, 8'd0, 16'd2, 16'd2);
    put_word(16'd8);
    repeat (8) put(8'($urandom));
    put_word(16'd3);
    repeat (3) put(8'($urandom));
    // Bad signature together with a bad version, then a dropped byte.
    put(SIG_CHARS[0], 1'b1); put(8'h58); put(SIG_CHARS[2]); put(8'd0);
    put(SIG_CHARS[0]);
    put_sig(); put(8'd0);
    put_sig(); put(8'd4);
    put_sig(); put(8'd255);
    // Unsupported compression shows up at the first row length.
    put_head(8'd2, 8'd2, 8'd0, 16'd1, 16'd1);
    put_word(16'd3);
    // Zero height ends at once, compression unchecked.
    put_head(8'd2, 8'd7, 8'd0, 16'd5, 16'd0);
    // Zero width: empty rows, with and without skipped bytes.
    put_head(8'd3, 8'd0, 8'd1, 16'd0, 16'd2);
    put_word(16'd0);
    put_word(16'd2);
    put(8'h5A); put(8'hA5);
    put_head(8'd1, 8'd0, 8'd0, 16'd0, 16'd1);
    put_word(16'd0);
    // Largest dimensions, abandoned mid-row by the next file.
    put_head(8'd3, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    put_word(16'd10);
    put(8'd3);
    // Zero-count pair followed by a real one.
    put_head(8'd2, 8'd1, 8'd0, 16'd1, 16'd1);
    put_word(16'd8);
    put(8'd0); repeat (3) put(8'($urandom));
    put(8'd1); repeat (3) put(8'($urandom));
    send_all();

    while (bytes_sent < ITEM_TARGET) begin
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
      if (!pressure_done && bytes_sent > 500) begin
        // Hold the output for a long stretch while bytes keep coming, then let it drain.
        hold_req = 1'b1;
        no_gap = 1'b1;
        put_head(8'd3, 8'd1, 8'($urandom_range(0, 1)), 16'd4, 16'd6);
        repeat (6) begin
          put_word(16'd20);
          repeat (4) begin
            put(8'd1);
            repeat (4) put(8'($urandom));
          end
        end
        send_all();
        no_gap = 1'b0;
        wait_drained();
        pressure_done = 1'b1;
      end
      if (bytes_sent + CALM_TAIL > ITEM_TARGET) calm = 1'b1;
      add_random_file();
      send_all();
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (sb.fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
